[rtl/rrf_pkg.sv]
// Shared constants and types for the RGB rainbow fade PWM block.
`timescale 1ns / 1ps

package rrf_pkg;

  // Level, counter and config widths
  localparam int LEVEL_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int PHASE_W     = 3;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'b1;

  // Config reset values
  localparam logic [CFG_WIDTH-1:0] FULL_LEVEL_RESET = 16'd255;
  localparam logic [CFG_WIDTH-1:0] STEP_SIZE_RESET  = 16'd1;

  // Red starts at the reset top level, masked to the level width
  localparam logic [LEVEL_WIDTH-1:0] RED_LEVEL_RESET = LEVEL_WIDTH'(FULL_LEVEL_RESET);

  // Fade phase codes
  localparam logic [PHASE_W-1:0] PH_RED_YEL  = 3'd0;  // green up
  localparam logic [PHASE_W-1:0] PH_YEL_GRN  = 3'd1;  // red down
  localparam logic [PHASE_W-1:0] PH_GRN_CYN  = 3'd2;  // blue up
  localparam logic [PHASE_W-1:0] PH_CYN_BLU  = 3'd3;  // green down
  localparam logic [PHASE_W-1:0] PH_BLU_VIO  = 3'd4;  // red up
  localparam logic [PHASE_W-1:0] PH_VIO_RED  = 3'd5;  // blue down

  // One result item
  typedef struct packed {
    logic               red_off;
    logic               green_off;
    logic               blue_off;
    logic [PHASE_W-1:0] fade_phase;
  } rrf_result_t;

endpackage

[rtl/rrf_fade_core.sv]
// PWM slot counter, channel levels, fade sequencer and config registers.
`timescale 1ns / 1ps

module rrf_fade_core
  import rrf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 item_acc_i,
  input  logic                 tick_i,
  output rrf_result_t          result_o
);

  localparam int SUM_W = CFG_WIDTH + 1;

  logic [CFG_WIDTH-1:0]   full_level_q, step_size_q;
  logic [LEVEL_WIDTH-1:0] red_q, green_q, blue_q, slot_q;
  logic [LEVEL_WIDTH-1:0] red_d, green_d, blue_d, slot_d;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [2:0]             drive_q, drive_d;

  logic [LEVEL_WIDTH-1:0] top_lvl, sel_lvl, up_val, dn_val, new_lvl;
  logic [SUM_W-1:0]       up_sum;
  logic                   up_hit, dn_zero, ramp_up, ramp_hit, wrap;

  // Clamp the top to what the level width holds
  assign top_lvl = (full_level_q > CFG_WIDTH'(LEVEL_MAX)) ? LEVEL_MAX
                                                          : full_level_q[LEVEL_WIDTH-1:0];
  assign wrap    = slot_q >= top_lvl;

  // Level ramped in this phase
  always_comb begin
    sel_lvl = '0;
    ramp_up = 1'b0;
    case (phase_q)
      PH_RED_YEL: begin sel_lvl = green_q; ramp_up = 1'b1; end
      PH_YEL_GRN: begin sel_lvl = red_q;                   end
      PH_GRN_CYN: begin sel_lvl = blue_q;  ramp_up = 1'b1; end
      PH_CYN_BLU: begin sel_lvl = green_q;                 end
      PH_BLU_VIO: begin sel_lvl = red_q;   ramp_up = 1'b1; end
      PH_VIO_RED: begin sel_lvl = blue_q;                  end
      default:    begin sel_lvl = '0;                      end
    endcase
  end

  // Saturating ramp up and down
  assign up_sum  = SUM_W'(sel_lvl) + SUM_W'(step_size_q);
  assign up_hit  = up_sum >= SUM_W'(top_lvl);
  assign up_val  = up_hit ? top_lvl : up_sum[LEVEL_WIDTH-1:0];
  assign dn_zero = CFG_WIDTH'(sel_lvl) <= step_size_q;
  assign dn_val  = dn_zero ? '0 : (sel_lvl - step_size_q[LEVEL_WIDTH-1:0]);
  assign new_lvl  = ramp_up ? up_val : dn_val;
  assign ramp_hit = ramp_up ? up_hit : dn_zero;

  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    slot_d  = slot_q;
    phase_d = phase_q;
    drive_d = drive_q;
    if (item_acc_i && tick_i) begin
      drive_d = {slot_q >= blue_q, slot_q >= green_q, slot_q >= red_q};
      if (wrap) begin
        case (phase_q)
          PH_RED_YEL, PH_CYN_BLU: green_d = new_lvl;
          PH_YEL_GRN, PH_BLU_VIO: red_d   = new_lvl;
          PH_GRN_CYN, PH_VIO_RED: blue_d  = new_lvl;
          default:                phase_d = PH_RED_YEL;
        endcase
        if (ramp_hit && (phase_q <= PH_VIO_RED)) begin
          phase_d = (phase_q == PH_VIO_RED) ? PH_RED_YEL : phase_q + PHASE_W'(1);
        end
        slot_d = LEVEL_WIDTH'(1);
      end else begin
        slot_d = slot_q + LEVEL_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_level_q <= FULL_LEVEL_RESET;
      step_size_q  <= STEP_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FULL_LEVEL: full_level_q <= cfg_data_i;
        CFG_STEP_SIZE:  step_size_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= RED_LEVEL_RESET;
      green_q <= '0;
      blue_q  <= '0;
      slot_q  <= '0;
      phase_q <= PH_RED_YEL;
      drive_q <= '0;
    end else begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      slot_q  <= slot_d;
      phase_q <= phase_d;
      drive_q <= drive_d;
    end
  end

  assign result_o.red_off    = drive_d[0];
  assign result_o.green_off  = drive_d[1];
  assign result_o.blue_off   = drive_d[2];
  assign result_o.fade_phase = phase_d;

  // Phase only moves on a counter wrap
  a_phase_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc_i && tick_i && !wrap) |=> $stable(phase_q))
    else $error("phase changed without a counter wrap");

  // Idle items leave the counter alone
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc_i && !tick_i) |=> ($stable(slot_q) && $stable(drive_q)))
    else $error("idle item changed counter or drive bits");

  // Only the six fade phases ever occur
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_VIO_RED)
    else $error("phase left the six-phase wheel");

endmodule

[rtl/rrf_out_buf.sv]
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps

module rrf_out_buf
  import rrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rrf_result_t push_data_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rrf_result_t out_data_o
);

  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  rrf_result_t out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_data_d   = push_data_i;
        out_valid_d  = 1'b1;
      end else begin
        out_valid_d  = 1'b0;
      end
    end else if (push_i) begin
      skid_data_d  = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output is empty");

  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("item pushed under stall was not parked");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item not moved to output");

endmodule

[rtl/rgb_rainbow_fade_pwm.sv]
// Top level of the RGB rainbow fade PWM block.
`timescale 1ns / 1ps

// Three-channel software-style PWM for an RGB LED with a six-phase rainbow fade.
// Input channel: in_valid_i / in_stall_o carry one tick_i item. tick_i = 1
//   advances the PWM slot counter by one slot; tick_i = 0 changes nothing but
//   still yields a result repeating the held drive bits and phase.
// Output channel: out_valid_o / out_stall_i carry one result per input item:
//   red_off_o, green_off_o, blue_off_o (active low, 1 = dark) and fade_phase_o.
// Config: cfg_we_i writes cfg_data_i to full_level (index 0) or step_size
//   (index 1). Write only while no item is in flight.
// Results are registered in the output register, or in the skid stage while
//   the output stalls. Throughput: one item per cycle while in_stall_o is low.
// Stall: results wait in an output register plus a one-item skid stage, so an
//   item is still taken while one result waits; in_stall_o rises only once the
//   skid stage holds an item, and drops the cycle after the receiver takes one.
// Reset (rst_ni low, async): full_level 255, step_size 1, red level at top,
//   green and blue at zero, phase 0, counter 0, drive bits all lit, both
//   result slots empty.
module rgb_rainbow_fade_pwm
  import rrf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 tick_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 red_off_o,
  output logic                 green_off_o,
  output logic                 blue_off_o,
  output logic [PHASE_W-1:0]   fade_phase_o
);

  logic        item_acc, buf_full;
  rrf_result_t result, out_data;

  // Stall depends only on the skid register, never on in_valid_i
  assign in_stall_o = buf_full;
  assign item_acc   = in_valid_i && !buf_full;

  rrf_fade_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_acc_i (item_acc),
    .tick_i     (tick_i),
    .result_o   (result)
  );

  rrf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item_acc),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign red_off_o    = out_data.red_off;
  assign green_off_o  = out_data.green_off;
  assign blue_off_o   = out_data.blue_off;
  assign fade_phase_o = out_data.fade_phase;

endmodule

[tb/fade_sb_pkg.sv]
// Scoreboard class for the rainbow fade PWM bench: fade predictor plus in-order result check.
`timescale 1ns / 1ps

package fade_sb_pkg;
  import rrf_pkg::*;

  class fade_scoreboard;
    logic [CFG_WIDTH-1:0]   full_level;
    logic [CFG_WIDTH-1:0]   step_size;
    logic [LEVEL_WIDTH-1:0] red_lvl;
    logic [LEVEL_WIDTH-1:0] grn_lvl;
    logic [LEVEL_WIDTH-1:0] blu_lvl;
    logic [LEVEL_WIDTH-1:0] slot_cnt;
    logic [PHASE_W-1:0]     phase;
    bit                     red_dark;
    bit                     grn_dark;
    bit                     blu_dark;
    rrf_result_t            drive_q[$];
    int                     errors;

    function new();
      full_level = FULL_LEVEL_RESET;
      step_size  = STEP_SIZE_RESET;
      red_lvl    = RED_LEVEL_RESET;
      grn_lvl    = '0;
      blu_lvl    = '0;
      slot_cnt   = '0;
      phase      = PH_RED_YEL;
      red_dark   = 1'b0;
      grn_dark   = 1'b0;
      blu_dark   = 1'b0;
      errors     = 0;
    endfunction

    // Levels are left alone on a write, only the top and the step move.
    function void set_fade(logic [CFG_WIDTH-1:0] full, logic [CFG_WIDTH-1:0] step);
      full_level = full;
      step_size  = step;
    endfunction

    function int unsigned top_level();
      if (32'(full_level) > 32'(LEVEL_MAX)) return 32'(LEVEL_MAX);
      return 32'(full_level);
    endfunction

    function logic [LEVEL_WIDTH-1:0] ramp_up(input logic [LEVEL_WIDTH-1:0] lvl,
                                             input int unsigned top, output bit hit);
      int unsigned v;
      v = 32'(lvl) + 32'(step_size);
      if (v >= top) v = top;
      hit = (v >= top);
      return v[LEVEL_WIDTH-1:0];
    endfunction

    function logic [LEVEL_WIDTH-1:0] ramp_down(input logic [LEVEL_WIDTH-1:0] lvl,
                                               output bit hit);
      logic [LEVEL_WIDTH-1:0] r;
      if (32'(lvl) <= 32'(step_size)) r = '0;
      else r = LEVEL_WIDTH'(32'(lvl) - 32'(step_size));
      hit = (r == '0);
      return r;
    endfunction

    function void fade_step();
      int unsigned top;
      bit          hit;
      top = top_level();
      hit = 1'b0;
      case (phase)
        PH_RED_YEL: grn_lvl = ramp_up(grn_lvl, top, hit);
        PH_YEL_GRN: red_lvl = ramp_down(red_lvl, hit);
        PH_GRN_CYN: blu_lvl = ramp_up(blu_lvl, top, hit);
        PH_CYN_BLU: grn_lvl = ramp_down(grn_lvl, hit);
        PH_BLU_VIO: red_lvl = ramp_up(red_lvl, top, hit);
        PH_VIO_RED: blu_lvl = ramp_down(blu_lvl, hit);
        default:    phase = PH_RED_YEL;
      endcase
      if (hit) phase = (phase == PH_VIO_RED) ? PH_RED_YEL : phase + 1'b1;
    endfunction

    // One accepted item always yields exactly one result.
    function void note_tick(bit tick);
      rrf_result_t want;
      if (tick) begin
        red_dark = (slot_cnt >= red_lvl);
        grn_dark = (slot_cnt >= grn_lvl);
        blu_dark = (slot_cnt >= blu_lvl);
        if (32'(slot_cnt) >= top_level()) begin
          fade_step();
          slot_cnt = '0;
        end
        slot_cnt = slot_cnt + 1'b1;
      end
      want.red_off    = red_dark;
      want.green_off  = grn_dark;
      want.blue_off   = blu_dark;
      want.fade_phase = phase;
      drive_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(rrf_result_t got);
      rrf_result_t want;
      if (drive_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      want = drive_q.pop_front();
      if (got.red_off !== want.red_off)
        report_mismatch($sformatf("red_off %b, want %b", got.red_off, want.red_off));
      if (got.green_off !== want.green_off)
        report_mismatch($sformatf("green_off %b, want %b", got.green_off, want.green_off));
      if (got.blue_off !== want.blue_off)
        report_mismatch($sformatf("blue_off %b, want %b", got.blue_off, want.blue_off));
      if (got.fade_phase !== want.fade_phase)
        report_mismatch($sformatf("fade_phase %0d, want %0d", got.fade_phase,
                                  want.fade_phase));
    endtask

    function int pending();
      return drive_q.size();
    endfunction
  endclass

endpackage

[tb/tb_rgb_rainbow_fade_pwm.sv]
// Testbench for rgb_rainbow_fade_pwm: random tick streams under several fade settings.
`timescale 1ns / 1ps

module tb_rgb_rainbow_fade_pwm;
  import rrf_pkg::*;
  import fade_sb_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_WIDTH-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 tick_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 red_off_o;
  logic                 green_off_o;
  logic                 blue_off_o;
  logic [PHASE_W-1:0]   fade_phase_o;

  fade_scoreboard sb;
  rrf_result_t    seen;
  int             accepted_items;

  rgb_rainbow_fade_pwm u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tick_i       (tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_off_o    (red_off_o),
    .green_off_o  (green_off_o),
    .blue_off_o   (blue_off_o),
    .fade_phase_o (fade_phase_o)
  );

  // 20 ns clock, first rising edge at 10 ns.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Monitor: values read here are the ones present just before the edge, since
  // both the DUT and the drivers update in the NBA region. Results are checked
  // before the item of the same edge is noted; a result reaches the outputs only through a register.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.red_off    = red_off_o;
        seen.green_off  = green_off_o;
        seen.blue_off   = blue_off_o;
        seen.fade_phase = fade_phase_o;
        sb.check_result(seen);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_tick(tick_i);
        accepted_items++;
      end
    end
  end

  // Mostly short gaps between items, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offer one item and hold it until accepted. Valid stays high into the next
  // item when there is no gap, so it never drops and rises in one step.
  task automatic send_item(bit tick, int gap);
    in_valid_i <= 1'b1;
    tick_i     <= tick;
    do @(posedge clk_i); while (in_stall_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random ticks; about one in seven is an idle item.
  task automatic run_ticks(int n);
    for (int i = 0; i < n; i++) begin
      send_item($urandom_range(0, 99) < 85, pick_gap());
    end
  endtask

  // Drain all outstanding results, then let the pipeline settle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Reprogram both registers while idle; valid is low by now.
  task automatic set_fade(logic [CFG_WIDTH-1:0] full, logic [CFG_WIDTH-1:0] step);
    in_valid_i <= 1'b0;
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FULL_LEVEL;
    cfg_data_i <= full;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STEP_SIZE;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_fade(full, step);
  endtask

  // Receiver: random stalls, mostly short, a few long, plus free-running runs.
  // Once, well into the run, it holds off long enough for the block to fill up
  // and push back on the sender while items keep being offered.
  initial begin : rx_stall
    int  sel;
    int  n;
    bit  held_off;
    out_stall_i = 1'b0;
    held_off    = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && accepted_items >= 300) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        out_stall_i <= 1'b0;
        n = $urandom_range(1, 20);
      end else if (sel < 90) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_FULL_LEVEL;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    tick_i         = 1'b0;
    accepted_items = 0;
    sb             = new();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset values, idle items repeating the held drive bits.
    send_item(1'b0, 0);
    send_item(1'b0, 0);
    send_item(1'b1, 0);
    send_item(1'b1, 0);
    send_item(1'b0, 2);
    send_item(1'b1, 0);

    // Top of zero: a fade step on every tick; with the largest step every ramp
    // hits its limit at once, so the phase walks around the whole wheel.
    set_fade(16'd0, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_item(1'b1, 0);

    // Zero step: levels frozen, phase moves only where a level sits at its limit.
    set_fade(16'd3, 16'd0);
    for (int i = 0; i < 8; i++) send_item(1'b1, i % 3);

    // Random part across a spread of settings, extremes included. Going from a
    // wider top to a narrower one leaves levels above the new top.
    set_fade(16'd3, 16'd1);
    run_ticks(220);
    set_fade(16'd5, 16'd2);
    run_ticks(180);
    set_fade(16'd2, 16'd0);
    run_ticks(60);
    set_fade(16'd0, 16'd1);
    run_ticks(60);
    set_fade(16'd1, 16'hFFFF);
    run_ticks(150);
    set_fade(16'hFFFF, 16'hFFFF);
    run_ticks(100);
    set_fade(16'd7, 16'd3);
    run_ticks(180);
    set_fade(16'd1, 16'd1);
    run_ticks(120);
    set_fade(16'd4, 16'd1);
    run_ticks(80);

    in_valid_i <= 1'b0;
    wait_idle();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
